FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// Concurrent assertion on the house clock and reset names.
`define ASSERT_STD(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

FILE: sv/mce_pkg.sv
// Package for the Morse character encoder: types, constants and the code table.
`default_nettype none

package mce_pkg;

  // Segment lengths in time units
  localparam logic [2:0] UNITS_DOT        = 3'd1;
  localparam logic [2:0] UNITS_DASH       = 3'd3;
  localparam logic [2:0] UNITS_GAP        = 3'd1;
  localparam logic [2:0] UNITS_LETTER_END = 3'd2;
  localparam logic [2:0] UNITS_WORD       = 3'd4;

  // Character codes of interest
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
  localparam logic [5:0] DIGIT_BASE  = 6'd26;
  localparam int unsigned NUM_CODES  = 36;

  // Symbol count and dash mask, bit 0 is the first symbol
  typedef struct packed {
    logic [2:0] count;
    logic [4:0] dashes;
  } morse_code_t;

  // Entries 0..25 are a..z, entries 26..35 are 0..9
  localparam morse_code_t CODE_TABLE [NUM_CODES] = '{
    '{3'd2, 5'h02}, '{3'd4, 5'h01}, '{3'd4, 5'h05}, '{3'd3, 5'h01},
    '{3'd1, 5'h00}, '{3'd4, 5'h04}, '{3'd3, 5'h03}, '{3'd4, 5'h00},
    '{3'd2, 5'h00}, '{3'd4, 5'h0e}, '{3'd3, 5'h05}, '{3'd4, 5'h02},
    '{3'd2, 5'h03}, '{3'd2, 5'h01}, '{3'd3, 5'h07}, '{3'd4, 5'h06},
    '{3'd4, 5'h0b}, '{3'd3, 5'h02}, '{3'd3, 5'h00}, '{3'd1, 5'h01},
    '{3'd3, 5'h04}, '{3'd4, 5'h08}, '{3'd3, 5'h06}, '{3'd4, 5'h09},
    '{3'd4, 5'h0d}, '{3'd4, 5'h03},
    '{3'd5, 5'h1f}, '{3'd5, 5'h1e}, '{3'd5, 5'h1c}, '{3'd5, 5'h18},
    '{3'd5, 5'h10}, '{3'd5, 5'h00}, '{3'd5, 5'h01}, '{3'd5, 5'h03},
    '{3'd5, 5'h07}, '{3'd5, 5'h0f}
  };

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mce_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } mce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic recognised;
    logic seg_last;
    logic out_free;
  } mce_sts_t;

endpackage

`default_nettype wire

FILE: sv/mce_char_if.sv
// Input channel: one character word per handshake.
`default_nettype none

interface mce_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

FILE: sv/mce_seg_if.sv
// Output channel: one lamp segment word per handshake.
`default_nettype none

interface mce_seg_if;
  logic       valid;
  logic       ready;
  logic       lamp_on;
  logic [2:0] length_units;
  logic       last_segment;

  modport source (output valid, output lamp_on, output length_units,
                  output last_segment, input ready);
  modport sink   (input valid, input lamp_on, input length_units,
                  input last_segment, output ready);
endinterface

`default_nettype wire

FILE: sv/mce_ctrl.sv
// Controller state machine: accepts a character and sequences its segments.
`default_nettype none

module mce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mce_pkg::mce_sts_t sts_i,
  output mce_pkg::mce_cmd_t cmd_o
);
  import mce_pkg::*;

  mce_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        // unrecognised codes give nothing: stay idle
        if (in_valid_i && sts_i.recognised) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free && sts_i.seg_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/mce_dp.sv
// Datapath: character decode, symbol shifter and output segment register.
`default_nettype none

module mce_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        char_code_i,
  input  logic              out_ready_i,
  input  mce_pkg::mce_cmd_t cmd_i,
  output mce_pkg::mce_sts_t sts_o,
  output logic              out_valid_o,
  output logic              lamp_on_o,
  output logic [2:0]        length_units_o,
  output logic              last_segment_o
);
  import mce_pkg::*;

  logic        is_space, is_letter, is_digit;
  logic [5:0]  code_idx;
  morse_code_t code;

  logic       space_q, space_d;
  logic       gap_q, gap_d;
  logic [2:0] remain_q, remain_d;
  logic [4:0] dashes_q, dashes_d;

  logic       seg_lamp;
  logic [2:0] seg_len;
  logic       seg_last;

  logic       out_valid_q, out_valid_d;
  logic       lamp_q;
  logic [2:0] len_q;
  logic       last_q;

  // Character decode and table lookup
  always_comb begin
    is_space  = (char_code_i == CHAR_SPACE);
    is_letter = (char_code_i >= CHAR_LOW_A) && (char_code_i <= CHAR_LOW_Z);
    is_digit  = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
    if (is_letter) begin
      code_idx = 6'(char_code_i - CHAR_LOW_A);
    end else begin
      code_idx = DIGIT_BASE + 6'(char_code_i - CHAR_ZERO);
    end
    code = (is_letter || is_digit) ? CODE_TABLE[code_idx] : '0;
  end

  // Segment that goes out next
  always_comb begin
    if (space_q) begin
      seg_lamp = 1'b0;
      seg_len  = UNITS_WORD;
      seg_last = 1'b1;
    end else if (remain_q == 3'd0) begin
      seg_lamp = 1'b0;
      seg_len  = UNITS_LETTER_END;
      seg_last = 1'b1;
    end else if (!gap_q) begin
      seg_lamp = 1'b1;
      seg_len  = dashes_q[0] ? UNITS_DASH : UNITS_DOT;
      seg_last = 1'b0;
    end else begin
      seg_lamp = 1'b0;
      seg_len  = UNITS_GAP;
      seg_last = 1'b0;
    end
  end

  // Symbol sequencing: mark, then gap, then shift to the next symbol
  always_comb begin
    space_d  = space_q;
    gap_d    = gap_q;
    remain_d = remain_q;
    dashes_d = dashes_q;
    if (cmd_i.load) begin
      space_d  = is_space;
      gap_d    = 1'b0;
      remain_d = code.count;
      dashes_d = code.dashes;
    end else if (cmd_i.emit && !space_q && (remain_q != 3'd0)) begin
      if (gap_q) begin
        gap_d    = 1'b0;
        remain_d = remain_q - 3'd1;
        dashes_d = dashes_q >> 1;
      end else begin
        gap_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q  <= 1'b0;
      gap_q    <= 1'b0;
      remain_q <= 3'd0;
      dashes_q <= 5'd0;
    end else begin
      space_q  <= space_d;
      gap_q    <= gap_d;
      remain_q <= remain_d;
      dashes_q <= dashes_d;
    end
  end

  // Output word register
  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      lamp_q <= seg_lamp;
      len_q  <= seg_len;
      last_q <= seg_last;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.recognised = is_space || is_letter || is_digit;
    sts_o.seg_last   = seg_last;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign lamp_on_o      = lamp_q;
  assign length_units_o = len_q;
  assign last_segment_o = last_q;

endmodule

`default_nettype wire

FILE: sv/morse_character_encoder.sv
// Top level of the Morse character encoder.
// Takes one ASCII character word (a-z, 0-9 or space) and returns its Morse
// rendering as lamp segment words: a dot is lit for 1 unit, a dash for 3,
// each symbol is followed by 1 unit dark, and a letter or digit closes with
// a 2-unit dark segment flagged last; a space is a single 4-unit dark
// segment flagged last. Any other code is taken and yields no words. A
// character of n symbols gives 2n+1 words at one per cycle while the sink
// takes them; the segment sequencer loads one word per cycle into the single
// output register whenever that register is free or its word is being taken.
// The next character is accepted as soon as the last word of the current
// one has been loaded, while that word may still be waiting.
`default_nettype none

module morse_character_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  mce_char_if.sink    char_i,
  mce_seg_if.source   seg_o
);
  import mce_pkg::*;

  mce_cmd_t cmd;
  mce_sts_t sts;

  // Controller
  mce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  mce_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_code_i    (char_i.char_code),
    .out_ready_i    (seg_o.ready),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (seg_o.valid),
    .lamp_on_o      (seg_o.lamp_on),
    .length_units_o (seg_o.length_units),
    .last_segment_o (seg_o.last_segment)
  );

endmodule

`default_nettype wire

FILE: sv/mce_checker.sv
// Port-level checker for the Morse character encoder, with its bind.
`default_nettype none
`include "assert_macros.svh"

module mce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       lamp_on_i,
  input logic [2:0] length_units_i,
  input logic       last_segment_i
);
  import mce_pkg::*;

  logic [4:0] seg_word;
  logic       len_mark;
  logic       len_close;

  // Segment fields as one word, and the lengths each kind of segment may take
  assign seg_word  = {lamp_on_i, length_units_i, last_segment_i};
  assign len_mark  = (length_units_i == UNITS_DOT) || (length_units_i == UNITS_DASH);
  assign len_close = (length_units_i == UNITS_LETTER_END) || (length_units_i == UNITS_WORD);

  // A waiting word holds until taken
  `ASSERT_STD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(seg_word))

  // A lit segment is a dot or a dash, never the closing one
  `ASSERT_STD(a_lit_shape, out_valid_i && lamp_on_i |-> !last_segment_i && len_mark)

  // Closing segments are the letter end or the word gap
  `ASSERT_STD(a_last_shape, out_valid_i && last_segment_i |-> !lamp_on_i && len_close)

  // A dark segment that is not closing is the symbol gap
  `ASSERT_STD(a_gap_shape, out_valid_i && !lamp_on_i && !last_segment_i |-> length_units_i == UNITS_GAP)

endmodule

bind morse_character_encoder mce_checker u_mce_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (seg_o.valid),
  .out_ready_i    (seg_o.ready),
  .lamp_on_i      (seg_o.lamp_on),
  .length_units_i (seg_o.length_units),
  .last_segment_i (seg_o.last_segment)
);

`default_nettype wire
